// File: rtl/stsd_pkg.sv
// shared constants and beat type for the signed tenths display formatter
// no dependencies; every other rtl file imports this package
`default_nettype none

package stsd_pkg;

  // display geometry
  localparam int DIGIT_COUNT = 4;
  localparam int OUT_DIGITS  = 4;
  localparam int DIGIT_SPAN  = (DIGIT_COUNT > OUT_DIGITS) ? DIGIT_COUNT : OUT_DIGITS;
  localparam int DIV_COUNT   = DIGIT_COUNT + 1;
  localparam int TOP_W       = $clog2(DIGIT_COUNT + 1);

  // input value width
  localparam int VALUE_W = 21;

  // divide by ten through a reciprocal: q = (x * DIV10_MUL) >> DIV10_SHIFT,
  // exact for every x below 2**22
  localparam int                 DIV10_SHIFT = 24;
  localparam logic [VALUE_W-1:0] DIV10_MUL   = VALUE_W'(1677722);
  localparam int                 PROD_W      = 2 * VALUE_W;

  // digit codes
  localparam logic [3:0] CODE_BLANK = 4'hF;
  localparam logic [3:0] CODE_MINUS = 4'hA;
  localparam logic [7:0] POINT_BIT  = 8'h80;

  // one beat as it travels down the pipeline
  typedef struct packed {
    logic                        neg;
    logic                        point;
    logic [VALUE_W-1:0]          src;
    logic [VALUE_W-1:0]          n;
    logic [DIGIT_COUNT-1:0][3:0] digs;
  } beat_t;

endpackage

`default_nettype wire

// File: rtl/stsd_front.sv
// entry stage: splits the signed tenths value into sign and magnitude
// depends on stsd_pkg
`default_nettype none

module stsd_front
  import stsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  output logic                    up_stall,
  input  wire logic [VALUE_W-1:0] up_value,
  output logic                    dn_valid,
  input  wire logic               dn_stall,
  output beat_t                   dn_beat
);

  logic  v_r;
  beat_t beat_r;
  beat_t beat_nxt;
  logic  en;

  // stage advances when empty or when downstream takes the beat
  assign en       = !v_r || !dn_stall;
  assign up_stall = !en;

  // two's complement magnitude, fits 21 bits even for the most negative value
  always_comb begin
    beat_nxt       = '0;
    beat_nxt.neg   = up_value[VALUE_W-1];
    beat_nxt.n     = up_value[VALUE_W-1] ? (~up_value + VALUE_W'(1)) : up_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_beat  = beat_r;

endmodule

`default_nettype wire

// File: rtl/stsd_div10.sv
// two-stage divide-by-ten step: reciprocal multiply, then quotient and remainder
// depends on stsd_pkg; remainder is shifted into the top of the digit row
`default_nettype none

module stsd_div10
  import stsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_stall,
  input  wire beat_t up_beat,
  output logic       dn_valid,
  input  wire logic  dn_stall,
  output beat_t      dn_beat
);

  logic               a_v_r;
  beat_t              a_beat_r;
  logic [PROD_W-1:0]  a_prod_r;
  logic               b_v_r;
  beat_t              b_beat_r;
  beat_t              b_beat_nxt;
  logic               a_en;
  logic               b_en;
  logic [VALUE_W-1:0] quo;
  logic [VALUE_W-1:0] rem_full;

  // stall chain, collapsing bubbles
  assign b_en     = !b_v_r || !dn_stall;
  assign a_en     = !a_v_r || b_en;
  assign up_stall = !a_en;

  // stage a: reciprocal product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_en) begin
      a_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && up_valid) begin
      a_beat_r <= up_beat;
      a_prod_r <= PROD_W'(up_beat.n) * PROD_W'(DIV10_MUL);
    end
  end

  // stage b: quotient, remainder by x - 8q - 2q
  always_comb begin
    quo            = VALUE_W'(a_prod_r[PROD_W-1:DIV10_SHIFT]);
    rem_full       = a_beat_r.n - (quo << 3) - (quo << 1);
    b_beat_nxt     = a_beat_r;
    b_beat_nxt.src = a_beat_r.n;
    b_beat_nxt.n   = quo;
    b_beat_nxt.digs = {rem_full[3:0], a_beat_r.digs[DIGIT_COUNT-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en && a_v_r) begin
      b_beat_r <= b_beat_nxt;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_beat  = b_beat_r;

endmodule

`default_nettype wire

// File: rtl/stsd_format.sv
// output stage: blanking, minus placement, decimal point and fit check
// depends on stsd_pkg; holds the output register of the block
`default_nettype none

module stsd_format
  import stsd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_stall,
  input  wire beat_t up_beat,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [7:0] out_digit_code_0,
  output logic [7:0] out_digit_code_1,
  output logic [7:0] out_digit_code_2,
  output logic [7:0] out_digit_code_3,
  output logic       out_fits
);

  logic             v_r;
  logic [7:0]       code_r [OUT_DIGITS];
  logic [7:0]       code_nxt [OUT_DIGITS];
  logic             fits_r;
  logic             fits_nxt;
  logic [3:0]       dig_w [DIGIT_SPAN];
  logic [TOP_W-1:0] top;
  logic [TOP_W-1:0] minus_pos;
  logic             sign_fail;
  logic             en;

  assign en       = !v_r || !out_stall;
  assign up_stall = !en;

  // highest nonzero digit, point digit counts as shown
  always_comb begin
    for (int p = 0; p < DIGIT_SPAN; p++) begin
      dig_w[p] = CODE_BLANK;
    end
    top = '0;
    for (int p = 0; p < DIGIT_COUNT; p++) begin
      dig_w[p] = up_beat.digs[p];
      if (up_beat.digs[p] != 4'd0) begin
        top = TOP_W'(p);
      end
    end
    if (up_beat.point && (top < TOP_W'(1))) begin
      top = TOP_W'(1);
    end
    minus_pos = top + TOP_W'(1);
    sign_fail = up_beat.neg && (minus_pos >= TOP_W'(DIGIT_COUNT));
    fits_nxt  = (up_beat.n == '0) && !sign_fail;
  end

  // per-digit code
  always_comb begin
    for (int p = 0; p < OUT_DIGITS; p++) begin
      if (TOP_W'(p) > top || p >= DIGIT_COUNT) begin
        if (up_beat.neg && (TOP_W'(p) == minus_pos) && p < DIGIT_COUNT) begin
          code_nxt[p] = {4'd0, CODE_MINUS};
        end else begin
          code_nxt[p] = {4'd0, CODE_BLANK};
        end
      end else begin
        code_nxt[p] = {4'd0, dig_w[p]};
      end
      if (up_beat.point && p == 1) begin
        code_nxt[p] = code_nxt[p] | POINT_BIT;
      end
      if (!fits_nxt) begin
        code_nxt[p] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      code_r <= code_nxt;
      fits_r <= fits_nxt;
    end
  end

  assign out_valid        = v_r;
  assign out_digit_code_0 = code_r[0];
  assign out_digit_code_1 = code_r[1];
  assign out_digit_code_2 = code_r[2];
  assign out_digit_code_3 = code_r[3];
  assign out_fits         = fits_r;

endmodule

`default_nettype wire

// File: rtl/signed_tenths_to_seven_segment_digits_core.sv
// top level: signed tenths to seven-segment digit codes, fully pipelined
// depends on stsd_pkg, stsd_front, stsd_div10, stsd_format
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   in      | sink      | in_valid, in_stall, in_value_tenths[20:0]
//   out     | source    | out_valid, out_stall, out_digit_code_0..3, out_fits
//
// one beat accepted per cycle when the output is not held; the pipe is one
// entry stage, one two-stage divide-by-ten unit per digit plus one for the
// tenths test, and the output register. stalls ripple back only through full
// stages, so bubbles close up. synchronous reset clears the valid bits only.
`default_nettype none

module signed_tenths_to_seven_segment_digits_core
  import stsd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [VALUE_W-1:0] in_value_tenths,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_digit_code_0,
  output logic [7:0]              out_digit_code_1,
  output logic [7:0]              out_digit_code_2,
  output logic [7:0]              out_digit_code_3,
  output logic                    out_fits
);

  logic  f_valid;
  logic  f_stall;
  beat_t f_beat;
  logic  d_up_valid [DIV_COUNT];
  logic  d_up_stall [DIV_COUNT];
  beat_t d_up_beat  [DIV_COUNT];
  logic  d_dn_valid [DIV_COUNT];
  logic  d_dn_stall [DIV_COUNT];
  beat_t d_dn_beat  [DIV_COUNT];
  beat_t pick_beat;
  logic  fmt_stall;

  // sign and magnitude
  stsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_value (in_value_tenths),
    .dn_valid (f_valid),
    .dn_stall (f_stall),
    .dn_beat  (f_beat)
  );

  assign d_up_valid[0] = f_valid;
  assign d_up_beat[0]  = f_beat;
  assign f_stall       = d_up_stall[0];

  // tenths nonzero: show the whole magnitude with a point, else drop the zero
  always_comb begin
    pick_beat = d_dn_beat[0];
    if (d_dn_beat[0].digs[DIGIT_COUNT-1] != 4'd0) begin
      pick_beat.n     = d_dn_beat[0].src;
      pick_beat.point = 1'b1;
    end else begin
      pick_beat.point = 1'b0;
    end
  end

  // chain of divide-by-ten units
  for (genvar i = 0; i < DIV_COUNT; i++) begin : g_div
    if (i > 0) begin : g_link
      assign d_up_valid[i]   = d_dn_valid[i-1];
      assign d_up_beat[i]    = (i == 1) ? pick_beat : d_dn_beat[i-1];
      assign d_dn_stall[i-1] = d_up_stall[i];
    end
    stsd_div10 u_div10 (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (d_up_valid[i]),
      .up_stall (d_up_stall[i]),
      .up_beat  (d_up_beat[i]),
      .dn_valid (d_dn_valid[i]),
      .dn_stall (d_dn_stall[i]),
      .dn_beat  (d_dn_beat[i])
    );
  end

  assign d_dn_stall[DIV_COUNT-1] = fmt_stall;

  // final codes and output register
  stsd_format u_format (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (d_dn_valid[DIV_COUNT-1]),
    .up_stall         (fmt_stall),
    .up_beat          (d_dn_beat[DIV_COUNT-1]),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digit_code_0 (out_digit_code_0),
    .out_digit_code_1 (out_digit_code_1),
    .out_digit_code_2 (out_digit_code_2),
    .out_digit_code_3 (out_digit_code_3),
    .out_fits         (out_fits)
  );

endmodule

`default_nettype wire

// File: rtl/stsd_chk.sv
// port-level checks for the signed tenths display formatter, bound to the top
// depends on stsd_pkg
`default_nettype none

module stsd_chk
  import stsd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_digit_code_0,
  input wire logic [7:0] out_digit_code_1,
  input wire logic [7:0] out_digit_code_2,
  input wire logic [7:0] out_digit_code_3,
  input wire logic       out_fits
);

  // no beat leaves right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // input stalls only when the whole pipe is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in the pipe");

  // a beat that does not fit shows all-zero codes
  a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fits) |-> (out_digit_code_0 == 8'd0 && out_digit_code_1 == 8'd0
                                  && out_digit_code_2 == 8'd0 && out_digit_code_3 == 8'd0))
    else $error("nonzero codes on a beat that does not fit");

  // rightmost digit is always a plain decimal digit when the number fits
  a_digit0: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fits) |-> (out_digit_code_0[7:4] == 4'd0
                                 && out_digit_code_0[3:0] <= 4'd9))
    else $error("rightmost digit code is not a decimal digit");

  // a held beat stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_digit_code_0)
                                  && $stable(out_digit_code_1) && $stable(out_digit_code_2)
                                  && $stable(out_digit_code_3) && $stable(out_fits)))
    else $error("output beat changed while stalled");

endmodule

bind signed_tenths_to_seven_segment_digits_core stsd_chk u_stsd_chk (.*);

`default_nettype wire
